// ----- rtl/urlpd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// urlpd_pkg
// Shared types, constants and character helpers for the percent decoder.
// ----------------------------------------------------------------------------
package urlpd_pkg;

   localparam logic [7:0] PCT_CHAR    = 8'h25;
   localparam logic [7:0] DROP_LIMIT  = 8'hF7;
   localparam int         QUEUE_DEPTH = 4;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_PCT,
      PH_DIGIT
   } urlpd_phase_type;

   // one decoded operation: up to three output bytes, count of valid ones
   typedef struct packed {
      logic [1:0]      count;
      logic [2:0][7:0] data;
   } urlpd_op_type;

   function automatic logic is_hex(input logic [7:0] c);
      is_hex = c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]};
   endfunction

   function automatic logic [3:0] hex_val(input logic [7:0] c);
      logic [7:0] v;
      v = 8'h00;
      if (c inside {[8'h30:8'h39]}) begin
         v = c - 8'h30;
      end else if (c inside {[8'h41:8'h46]}) begin
         v = c - 8'h37;
      end else if (c inside {[8'h61:8'h66]}) begin
         v = c - 8'h57;
      end
      hex_val = v[3:0];
   endfunction

endpackage

// ----- rtl/urlpd_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// urlpd_front
// Escape tracker: classifies each input byte and builds the output operation.
// ----------------------------------------------------------------------------
module urlpd_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  logic [7:0]            in_byte,
   input  logic                  string_end,
   output logic                  push,
   output urlpd_pkg::urlpd_op_type op
);

   urlpd_pkg::urlpd_phase_type phase_ff, phase_in;
   logic [7:0]                 digit_ff, digit_in;
   logic                       hex;
   logic [7:0]                 value;

   assign hex   = urlpd_pkg::is_hex(in_byte);
   assign value = {urlpd_pkg::hex_val(digit_ff), urlpd_pkg::hex_val(in_byte)};

   // next state
   always_comb begin
      phase_in = phase_ff;
      digit_in = digit_ff;
      if (accept) begin
         case (phase_ff)
            urlpd_pkg::PH_PCT: begin
               if (hex) begin
                  phase_in = urlpd_pkg::PH_DIGIT;
                  digit_in = in_byte;
               end else begin
                  phase_in = urlpd_pkg::PH_IDLE;
                  digit_in = 8'h00;
               end
            end
            urlpd_pkg::PH_DIGIT: begin
               phase_in = urlpd_pkg::PH_IDLE;
               digit_in = 8'h00;
            end
            default: begin
               phase_in = (in_byte == urlpd_pkg::PCT_CHAR) ? urlpd_pkg::PH_PCT
                                                           : urlpd_pkg::PH_IDLE;
            end
         endcase
         if (string_end) begin
            phase_in = urlpd_pkg::PH_IDLE;
            digit_in = 8'h00;
         end
      end
   end

   // operation for this beat
   always_comb begin
      op.count   = 2'd0;
      op.data[0] = in_byte;
      op.data[1] = 8'h00;
      op.data[2] = 8'h00;
      case (phase_ff)
         urlpd_pkg::PH_PCT: begin
            if (!hex) begin
               op.count   = 2'd2;
               op.data[0] = urlpd_pkg::PCT_CHAR;
               op.data[1] = in_byte;
            end
         end
         urlpd_pkg::PH_DIGIT: begin
            if (hex) begin
               op.data[0] = value;
               if (value != 8'h00 && value < urlpd_pkg::DROP_LIMIT) begin
                  op.count = 2'd1;
               end
            end else begin
               op.count   = 2'd3;
               op.data[0] = urlpd_pkg::PCT_CHAR;
               op.data[1] = digit_ff;
               op.data[2] = in_byte;
            end
         end
         default: begin
            if (in_byte != urlpd_pkg::PCT_CHAR) begin
               op.count = 2'd1;
            end
         end
      endcase
   end

   assign push = accept && (op.count != 2'd0);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= urlpd_pkg::PH_IDLE;
         digit_ff <= 8'h00;
      end else begin
         phase_ff <= phase_in;
         digit_ff <= digit_in;
      end
   end

endmodule

// ----- rtl/urlpd_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// urlpd_queue
// Short operation queue between the escape tracker and the output sequencer.
// ----------------------------------------------------------------------------
module urlpd_queue #(
   parameter int Depth = urlpd_pkg::QUEUE_DEPTH
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  urlpd_pkg::urlpd_op_type push_op,
   input  logic                    pop,
   output logic                    full,
   output logic                    empty,
   output urlpd_pkg::urlpd_op_type head
);

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);

   urlpd_pkg::urlpd_op_type entry_ff [Depth];
   logic [PtrW-1:0]         wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]         rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]         count_ff, count_in;

   assign full  = (count_ff == CntW'(Depth));
   assign empty = (count_ff == '0);
   assign head  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_op;
      end
   end

endmodule

// ----- rtl/urlpd_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// urlpd_back
// Output sequencer: walks the bytes of the head operation into the output
// register, one beat per cycle unless a low rsp_ready stalls it.
// ----------------------------------------------------------------------------
module urlpd_back (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    empty,
   input  urlpd_pkg::urlpd_op_type head,
   output logic                    pop,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [7:0]              rsp_out_byte,
   output logic                    rsp_run_last
);

   logic       valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;
   logic       last_ff, last_in;
   logic [1:0] idx_ff, idx_in;
   logic       load;
   logic       at_end;

   // output register free or being drained this cycle
   assign load   = !valid_ff || rsp_ready;
   assign at_end = (idx_ff == head.count - 2'd1);
   assign pop    = load && !empty && at_end;

   always_comb begin
      valid_in = valid_ff;
      byte_in  = byte_ff;
      last_in  = last_ff;
      idx_in   = idx_ff;
      if (load) begin
         valid_in = !empty;
         if (!empty) begin
            byte_in = head.data[idx_ff];
            last_in = at_end;
            idx_in  = at_end ? 2'd0 : idx_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 2'd0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      last_ff <= last_in;
   end

   assign rsp_valid    = valid_ff;
   assign rsp_out_byte = byte_ff;
   assign rsp_run_last = last_ff;

endmodule

// ----- rtl/url_percent_decoder.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// url_percent_decoder
// Percent-escape decoder for a byte stream, up to three result beats per
// input beat.
// ----------------------------------------------------------------------------
//  channel  | direction | payload                          | handshake
//  req_     | in        | req_in_byte[7:0], req_string_end | req_valid/req_ready
//  rsp_     | out       | rsp_out_byte[7:0], rsp_run_last  | rsp_valid/rsp_ready
//
//  one input beat per cycle while the operation queue has room
//  the output sequencer drains one result per cycle while rsp_ready is high, so
//  an abort, with two or three results, holds it; the QueueDepth-entry queue
//  absorbs those bursts; results pass the queue, then the output register
//  synchronous reset clears the escape state, the queue and the output
//  valid flag; no clearing pass, inputs are taken the cycle after reset
// ----------------------------------------------------------------------------
module url_percent_decoder #(
   parameter int QueueDepth = urlpd_pkg::QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_in_byte,
   input  logic       req_string_end,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_run_last
);

   urlpd_pkg::urlpd_op_type push_op;
   urlpd_pkg::urlpd_op_type head;
   logic                    push;
   logic                    pop;
   logic                    full;
   logic                    empty;

   assign req_ready = !full;

   urlpd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (req_valid && req_ready),
      .in_byte    (req_in_byte),
      .string_end (req_string_end),
      .push       (push),
      .op         (push_op)
   );

   urlpd_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .push_op (push_op),
      .pop     (pop),
      .full    (full),
      .empty   (empty),
      .head    (head)
   );

   urlpd_back u_back (
      .clock        (clock),
      .reset        (reset),
      .empty        (empty),
      .head         (head),
      .pop          (pop),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_out_byte (rsp_out_byte),
      .rsp_run_last (rsp_run_last)
   );

endmodule

// ----- rtl/urlpd_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// urlpd_checker
// Port-level checks for the percent decoder, bound to the top level.
// ----------------------------------------------------------------------------
module urlpd_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_run_last
);

   logic       rsp_beat;
   logic       prev_last_ff;
   logic [1:0] run_cnt_ff;

   assign rsp_beat = rsp_valid && rsp_ready;

   // position inside the current run of results
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_last_ff <= 1'b1;
         run_cnt_ff   <= 2'd0;
      end else if (rsp_beat) begin
         prev_last_ff <= rsp_run_last;
         run_cnt_ff   <= rsp_run_last ? 2'd0 : run_cnt_ff + 2'd1;
      end
   end

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> (!rsp_valid && req_ready))
      else $error("outputs not idle after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte)
                                  && $stable(rsp_run_last))
      else $error("stalled result beat changed");

   a_run_opens_pct: assert property (@(posedge clock) disable iff (reset)
      rsp_beat && !rsp_run_last && prev_last_ff |->
         rsp_out_byte == urlpd_pkg::PCT_CHAR)
      else $error("multi-beat run does not open with a percent sign");

   a_run_length: assert property (@(posedge clock) disable iff (reset)
      rsp_beat && run_cnt_ff == 2'd2 |-> rsp_run_last)
      else $error("run longer than three beats");

endmodule

bind url_percent_decoder urlpd_checker u_urlpd_checker (.*);
